// ----- sv/mseu_pkg.sv -----
// ----------------------------------------------------------------------------
// mseu_pkg
// Shared opcodes, function codes and the execute result type of the MIPS
// subset execute core.
// ----------------------------------------------------------------------------
package mseu_pkg;

	// Default size of the data memory, as a byte address width.
	localparam int DMEM_ADDR_BITS_DEF = 12;
	// Width of the reported store address.
	localparam int STORE_ADDR_W = 12;
	// Number of general purpose registers.
	localparam int RF_DEPTH = 32;

	// Primary opcodes.
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_SLTI    = 6'h0a;
	localparam logic [5:0] OP_ANDI    = 6'h0c;
	localparam logic [5:0] OP_ORI     = 6'h0d;
	localparam logic [5:0] OP_XORI    = 6'h0e;
	localparam logic [5:0] OP_LUI     = 6'h0f;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SW      = 6'h2b;

	// Function codes of the special opcode.
	localparam logic [5:0] FN_JR  = 6'h08;
	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR  = 6'h25;
	localparam logic [5:0] FN_XOR = 6'h26;
	localparam logic [5:0] FN_NOR = 6'h27;
	localparam logic [5:0] FN_SLT = 6'h2a;

	// Link register written by jal.
	localparam logic [4:0] REG_RA = 5'd31;

	// Result of executing one instruction.
	typedef struct packed {
		logic [31:0] next_pc;
		logic        illegal;
		logic        wb_enable;
		logic [4:0]  wb_reg;
		logic [31:0] wb_value;
		logic        store_enable;
		logic        store_word;
		logic [31:0] store_data;
	} exec_res_t;

endpackage

// ----- sv/mips_subset_execute_core_unit.sv -----
// ----------------------------------------------------------------------------
// mips_subset_execute_core_unit
// Execute core for a MIPS32 subset, holding the PC, register file and a
// big-endian byte data memory.
// ----------------------------------------------------------------------------
// Each input transaction carries one instruction, executed at the current PC,
// and yields one output transaction with the next PC, the register write and
// the store it caused. The core takes a new instruction no earlier than the
// commit of the previous one. The register file is read as the instruction
// enters; the decode stage forms the data address (it needs the base register)
// and reads the data memory; the execute stage executes, and the write back of
// registers, memory and PC lands as it commits. A result leaves through an
// output register, so the next instruction is accepted while a result still
// waits to be taken. After reset the data memory is cleared by a pass over its
// 2^(DMEM_ADDR_BITS-2) word rows, one row per cycle, during which in_stall stays
// high; the register file reads as zero until each register is first written.
// ----------------------------------------------------------------------------
module mips_subset_execute_core_unit #(
	parameter int DMEM_ADDR_BITS = mseu_pkg::DMEM_ADDR_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [31:0]                       instr,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [31:0]                       next_pc,
	output logic                              illegal,
	output logic                              wb_enable,
	output logic [4:0]                        wb_reg,
	output logic [31:0]                       wb_value,
	output logic                              store_enable,
	output logic [mseu_pkg::STORE_ADDR_W-1:0] store_addr,
	output logic [31:0]                       store_data
);

	import mseu_pkg::*;

	// The data memory is four byte lanes, one per low address code.
	localparam int AW       = DMEM_ADDR_BITS;
	localparam int ROW_W    = AW - 2;
	localparam int ROWS     = 1 << ROW_W;
	localparam int RF_AW    = $clog2(RF_DEPTH);

	// Pipeline control.
	logic              in_accept;
	logic              s1_valid_s1;
	logic [31:0]       instr_s1;
	logic              s2_valid_s2;
	logic [31:0]       instr_s2;
	logic [31:0]       a_s2;
	logic [31:0]       b_s2;
	logic [AW-1:0]     addr_s2;
	logic              s1_advance;
	logic              commit;

	// Architectural state kept in flops.
	logic [31:0]       pc_q;
	logic [RF_DEPTH-1:0] rf_vld_q;
	logic              byp_vld_q;
	logic [4:0]        byp_reg_q;
	logic [31:0]       byp_val_q;

	// Data memory clearing pass.
	logic              clr_active_q;
	logic [ROW_W-1:0]  clr_row_q;

	// Register file reads.
	logic [31:0]       rf_rs_rdata;
	logic [31:0]       rf_rt_rdata;
	logic [4:0]        rs_s1;
	logic [4:0]        rt_s1;
	logic [31:0]       a_s1;
	logic [31:0]       b_s1;
	logic [31:0]       simm_s1;
	logic [31:0]       ea_s1;
	logic [AW-1:0]     addr_s1;

	// Data memory lanes.
	logic [3:0]            lane_we;
	logic [3:0][ROW_W-1:0] lane_waddr;
	logic [3:0][7:0]       lane_wdata;
	logic [3:0][ROW_W-1:0] lane_raddr;
	logic [3:0][7:0]       lane_rdata;

	exec_res_t         res;
	logic [31:0]       addr_ext;

	// Output register.
	logic              out_valid_q;
	exec_res_t         out_res_q;
	logic [STORE_ADDR_W-1:0] out_addr_q;

	// ------------------------------------------------------------------------
	// Handshake. A new instruction enters only when the execute stage is free
	// by the next cycle, so an instruction never reads the data memory before
	// the previous one has written it back.
	// ------------------------------------------------------------------------
	assign commit     = s2_valid_s2 && (!out_valid_q || !out_stall);
	assign in_stall   = clr_active_q || s1_valid_s1 || (s2_valid_s2 && !commit);
	assign in_accept  = in_valid && !in_stall;
	assign s1_advance = s1_valid_s1 && !s2_valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			s2_valid_s2 <= 1'b0;
		end else begin
			s1_valid_s1 <= in_accept || (s1_valid_s1 && !s1_advance);
			s2_valid_s2 <= s1_advance || (s2_valid_s2 && !commit);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			instr_s1 <= instr;
		end
		if (s1_advance) begin
			instr_s2 <= instr_s1;
			a_s2     <= a_s1;
			b_s2     <= b_s1;
			addr_s2  <= addr_s1;
		end
	end

	// ------------------------------------------------------------------------
	// Register file: two copies give the two read ports. The read is issued
	// straight from the incoming instruction when it is accepted.
	// ------------------------------------------------------------------------
	mseu_ram #(
		.WIDTH(32),
		.DEPTH(RF_DEPTH)
	) u_rf_rs (
		.clk  (clk),
		.we   (commit && res.wb_enable),
		.waddr(res.wb_reg),
		.wdata(res.wb_value),
		.re   (in_accept),
		.raddr(instr[25:21]),
		.rdata(rf_rs_rdata)
	);

	mseu_ram #(
		.WIDTH(32),
		.DEPTH(RF_DEPTH)
	) u_rf_rt (
		.clk  (clk),
		.we   (commit && res.wb_enable),
		.waddr(res.wb_reg),
		.wdata(res.wb_value),
		.re   (in_accept),
		.raddr(instr[20:16]),
		.rdata(rf_rt_rdata)
	);

	// A register never written reads as zero. The last write is held aside,
	// since it may land on the same edge as the read of the next instruction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q  <= '0;
			byp_vld_q <= 1'b0;
		end else if (commit && res.wb_enable) begin
			rf_vld_q[res.wb_reg[RF_AW-1:0]] <= 1'b1;
			byp_vld_q                       <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && res.wb_enable) begin
			byp_reg_q <= res.wb_reg;
			byp_val_q <= res.wb_value;
		end
	end

	assign rs_s1 = instr_s1[25:21];
	assign rt_s1 = instr_s1[20:16];

	always_comb begin
		if (byp_vld_q && byp_reg_q == rs_s1) begin
			a_s1 = byp_val_q;
		end else if (rf_vld_q[rs_s1]) begin
			a_s1 = rf_rs_rdata;
		end else begin
			a_s1 = '0;
		end
		if (byp_vld_q && byp_reg_q == rt_s1) begin
			b_s1 = byp_val_q;
		end else if (rf_vld_q[rt_s1]) begin
			b_s1 = rf_rt_rdata;
		end else begin
			b_s1 = '0;
		end
	end

	// Effective data address, wrapped to the memory size.
	assign simm_s1 = {{16{instr_s1[15]}}, instr_s1[15:0]};
	assign ea_s1   = a_s1 + simm_s1;
	assign addr_s1 = ea_s1[AW-1:0];

	// ------------------------------------------------------------------------
	// Data memory. Lane L holds every byte whose address ends in L. A word
	// access starting at any byte touches each lane once, in the row of the
	// byte that falls on that lane; the wrap at the top of memory falls out
	// of the address arithmetic.
	// ------------------------------------------------------------------------
	always_comb begin
		logic [1:0]    off_r;
		logic [1:0]    off_w;
		logic [AW-1:0] sum_r;
		logic [AW-1:0] sum_w;
		for (int l = 0; l < 4; l++) begin
			off_r         = 2'(2'(l) - addr_s1[1:0]);
			sum_r         = addr_s1 + AW'(off_r);
			lane_raddr[l] = sum_r[AW-1:2];

			off_w         = 2'(2'(l) - addr_s2[1:0]);
			sum_w         = addr_s2 + AW'(off_w);
			if (clr_active_q) begin
				lane_we[l]    = 1'b1;
				lane_waddr[l] = clr_row_q;
				lane_wdata[l] = '0;
			end else if (res.store_word) begin
				lane_we[l]    = commit;
				lane_waddr[l] = sum_w[AW-1:2];
				lane_wdata[l] = 8'(res.store_data >> (5'd24 - {off_w, 3'b000}));
			end else begin
				lane_we[l]    = commit && res.store_enable && (addr_s2[1:0] == 2'(l));
				lane_waddr[l] = addr_s2[AW-1:2];
				lane_wdata[l] = res.store_data[7:0];
			end
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		mseu_ram #(
			.WIDTH(8),
			.DEPTH(ROWS)
		) u_dmem (
			.clk  (clk),
			.we   (lane_we[l]),
			.waddr(lane_waddr[l]),
			.wdata(lane_wdata[l]),
			.re   (s1_advance),
			.raddr(lane_raddr[l]),
			.rdata(lane_rdata[l])
		);
	end

	// Clearing pass after reset, one row of all four lanes per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_row_q    <= '0;
		end else if (clr_active_q) begin
			clr_row_q <= clr_row_q + 1'b1;
			if (clr_row_q == ROW_W'(ROWS - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Execute and write back.
	// ------------------------------------------------------------------------
	mseu_exec u_exec (
		.instr    (instr_s2),
		.pc       (pc_q),
		.a        (a_s2),
		.b        (b_s2),
		.addr_lo  (addr_s2[1:0]),
		.lane_data(lane_rdata),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (commit) begin
			pc_q <= res.next_pc;
		end
	end

	assign addr_ext = 32'(addr_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= commit || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_res_q  <= res;
			out_addr_q <= res.store_enable ? addr_ext[STORE_ADDR_W-1:0] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign next_pc      = out_res_q.next_pc;
	assign illegal      = out_res_q.illegal;
	assign wb_enable    = out_res_q.wb_enable;
	assign wb_reg       = out_res_q.wb_reg;
	assign wb_value     = out_res_q.wb_value;
	assign store_enable = out_res_q.store_enable;
	assign store_addr   = out_addr_q;
	assign store_data   = out_res_q.store_data;

	// ------------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------------
	// No instruction may enter while the data memory is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !in_accept)
		else $error("instruction accepted during memory clear");

	// Decode and execute never overlap two instructions.
	a_single_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s1_advance |-> !s2_valid_s2 && !in_accept)
		else $error("two instructions overlap in the pipeline");

	// An illegal instruction neither writes state nor moves the PC.
	a_illegal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && res.illegal) |=> !wb_enable && !store_enable && pc_q == $past(pc_q))
		else $error("illegal instruction changed state");

	// $0 is never reported as written.
	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && wb_enable) |-> wb_reg != 5'd0)
		else $error("write to register zero reported");

endmodule

// ----- sv/mseu_ram.sv -----
// ----------------------------------------------------------------------------
// mseu_ram
// Generic simple dual-port RAM: one write port, one read port with a read
// enable and registered read data.
// ----------------------------------------------------------------------------
module mseu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/mseu_exec.sv -----
// ----------------------------------------------------------------------------
// mseu_exec
// Decode and execute of one instruction from its operands, the current PC
// and the four data memory byte lanes read for it.
// ----------------------------------------------------------------------------
module mseu_exec (
	input  logic [31:0]         instr,
	input  logic [31:0]         pc,
	input  logic [31:0]         a,
	input  logic [31:0]         b,
	input  logic [1:0]          addr_lo,
	input  logic [3:0][7:0]     lane_data,
	output mseu_pkg::exec_res_t res
);

	import mseu_pkg::*;

	logic [5:0]  op;
	logic [5:0]  fn;
	logic [4:0]  rs;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic [15:0] imm;
	logic [31:0] simm;
	logic [31:0] pc4;
	logic [31:0] br_target;
	logic [31:0] j_target;
	logic [31:0] ld_word;
	logic [7:0]  ld_byte;
	exec_res_t   r;

	assign op        = instr[31:26];
	assign fn        = instr[5:0];
	assign rs        = instr[25:21];
	assign rt        = instr[20:16];
	assign rd        = instr[15:11];
	assign imm       = instr[15:0];
	assign simm      = {{16{imm[15]}}, imm};
	assign pc4       = pc + 32'd4;
	assign br_target = pc4 + {simm[29:0], 2'b00};
	assign j_target  = {pc4[31:28], instr[25:0], 2'b00};

	// Big-endian: the byte at the lowest address is the most significant.
	assign ld_word = {lane_data[addr_lo], lane_data[2'(addr_lo + 2'd1)],
		lane_data[2'(addr_lo + 2'd2)], lane_data[2'(addr_lo + 2'd3)]};
	assign ld_byte = lane_data[addr_lo];

	always_comb begin
		r              = '0;
		r.next_pc      = pc4;
		unique case (op)
			OP_SPECIAL: begin
				r.wb_enable = 1'b1;
				r.wb_reg    = rd;
				unique case (fn)
					FN_ADD: r.wb_value = a + b;
					FN_SUB: r.wb_value = a - b;
					FN_AND: r.wb_value = a & b;
					FN_OR:  r.wb_value = a | b;
					FN_NOR: r.wb_value = ~(a | b);
					FN_XOR: r.wb_value = a ^ b;
					FN_SLT: r.wb_value = {31'd0, $signed(a) < $signed(b)};
					FN_JR: begin
						r.wb_enable = 1'b0;
						r.next_pc   = a;
					end
					default: begin
						r.illegal   = 1'b1;
					end
				endcase
			end
			OP_ADDI: begin
				r.wb_enable = 1'b1;
				r.wb_reg    = rt;
				r.wb_value  = a + simm;
			end
			OP_SLTI: begin
				r.wb_enable = 1'b1;
				r.wb_reg    = rt;
				r.wb_value  = {31'd0, $signed(a) < $signed(simm)};
			end
			OP_ANDI: begin
				r.wb_enable = 1'b1;
				r.wb_reg    = rt;
				r.wb_value  = a & {16'd0, imm};
			end
			OP_ORI: begin
				r.wb_enable = 1'b1;
				r.wb_reg    = rt;
				r.wb_value  = a | {16'd0, imm};
			end
			OP_XORI: begin
				r.wb_enable = 1'b1;
				r.wb_reg    = rt;
				r.wb_value  = a ^ {16'd0, imm};
			end
			OP_LW: begin
				r.wb_enable = 1'b1;
				r.wb_reg    = rt;
				r.wb_value  = ld_word;
			end
			OP_LB: begin
				r.wb_enable = 1'b1;
				r.wb_reg    = rt;
				r.wb_value  = {{24{ld_byte[7]}}, ld_byte};
			end
			OP_SW: begin
				r.store_enable = 1'b1;
				r.store_word   = 1'b1;
				r.store_data   = b;
			end
			OP_SB: begin
				r.store_enable = 1'b1;
				r.store_data   = {24'd0, b[7:0]};
			end
			OP_LUI: begin
				if (rs != 5'd0) begin
					r.illegal   = 1'b1;
				end else begin
					r.wb_enable = 1'b1;
					r.wb_reg    = rt;
					r.wb_value  = {imm, 16'd0};
				end
			end
			OP_BEQ: begin
				if (a == b) begin
					r.next_pc = br_target;
				end
			end
			OP_BNE: begin
				if (a != b) begin
					r.next_pc = br_target;
				end
			end
			OP_J: begin
				r.next_pc = j_target;
			end
			OP_JAL: begin
				r.next_pc   = j_target;
				r.wb_enable = 1'b1;
				r.wb_reg    = REG_RA;
				r.wb_value  = pc4;
			end
			default: begin
				r.illegal = 1'b1;
			end
		endcase

		// An unsupported instruction leaves all state as it was.
		if (r.illegal) begin
			r.next_pc      = pc;
			r.wb_enable    = 1'b0;
			r.store_enable = 1'b0;
		end
		// Writes to $0 are dropped.
		if (!r.wb_enable || r.wb_reg == 5'd0) begin
			r.wb_enable = 1'b0;
			r.wb_reg    = 5'd0;
			r.wb_value  = '0;
		end
		if (!r.store_enable) begin
			r.store_word = 1'b0;
			r.store_data = '0;
		end
		res = r;
	end

endmodule
